@@ rtl/ggc_pkg.sv @@
`timescale 1ns / 1ps

package ggc_pkg;

  // Default vertex capacity of the adjacency store
  localparam int DEF_MAX_VERTICES = 64;

  // Fixed field widths
  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;
  localparam int EDGES_W  = 16;

  // Register reset and result limits
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COLORS_SAT         = 7'd127;
  localparam logic [EDGES_W-1:0] EDGES_SAT          = 16'hFFFF;

  // Item kinds
  localparam logic KIND_ADD_EDGE = 1'b0;
  localparam logic KIND_COLOR    = 1'b1;

  typedef logic [COUNT_W-1:0] cfg_word_t;

  typedef struct packed {
    logic                kind;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] colors_needed;
    logic [EDGES_W-1:0] edges_added;
  } res_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // begin a coloring run
    logic edge_wr;   // store one edge
    logic row_rd;    // fetch adjacency row of current vertex
    logic scan;      // step neighbour scan
    logic srch;      // step first-fit color search
    logic color_wr;  // commit color of current vertex
    logic next_vtx;  // advance to next vertex
    logic out_load;  // load result register
  } ggc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_more;   // lower-indexed neighbours left to scan
    logic free_found;  // candidate color is not taken
    logic last_vtx;    // current vertex is the last one in use
    logic out_free;    // result register can take a new beat
  } ggc_sts_t;

endpackage

@@ rtl/ggc_stream_if.sv @@
`timescale 1ns / 1ps

interface ggc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ggc_ctrl.sv @@
`timescale 1ns / 1ps

module ggc_ctrl
  import ggc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_kind_i,
  output logic     in_ready_o,
  input  ggc_sts_t sts_i,
  output ggc_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ROW  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_SRCH = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Sequence the coloring walk
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_COLOR) begin
            cmd_o.start = 1'b1;
            state_d     = ST_ROW;
          end else begin
            cmd_o.edge_wr = 1'b1;
          end
        end
      end
      ST_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.scan_more) begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.free_found) begin
          cmd_o.color_wr = 1'b1;
          if (sts_i.last_vtx) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.next_vtx = 1'b1;
            state_d        = ST_ROW;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/ggc_datapath.sv @@
`timescale 1ns / 1ps

module ggc_datapath
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ggc_cmd_t            cmd_i,
  output ggc_sts_t            sts_o,
  input  logic                cfg_valid_i,
  input  cfg_word_t           cfg_data_i,
  input  logic [VERTEX_W-1:0] vertex_a_i,
  input  logic [VERTEX_W-1:0] vertex_b_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output res_item_t           res_data_o
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);

  // Lower-triangle adjacency: row max(a,b) holds bit min(a,b)
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_q;
  logic [AW-1:0]           vcol_mem [MAX_VERTICES];

  cfg_word_t           vcount_q;
  logic [EDGES_W-1:0]  edges_q;
  logic [NW-1:0]       n_q, n_eff;
  logic [AW-1:0]       i_q, j_q, c_q;
  logic [NW-1:0]       used_q, used_cand;
  logic [MAX_VERTICES-1:0] row_raw_q, row_eff, taken_q;
  logic                row_ok_q;
  logic                hit_q;
  logic [AW-1:0]       col_rd_q;
  logic                res_valid_q;
  res_item_t           res_q;

  logic                edge_ok;
  logic [AW-1:0]       addr_a, addr_b, wr_row, wr_col;
  logic [MAX_VERTICES-1:0] wr_bit, wr_mask;
  logic                scan_more;

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(vcount_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_q);
    end
  end

  // Decode the edge write
  assign edge_ok = (int'(vertex_a_i) < MAX_VERTICES) && (int'(vertex_b_i) < MAX_VERTICES);
  assign addr_a  = AW'(vertex_a_i);
  assign addr_b  = AW'(vertex_b_i);
  assign wr_row  = (addr_a >= addr_b) ? addr_a : addr_b;
  assign wr_col  = (addr_a >= addr_b) ? addr_b : addr_a;
  assign wr_bit  = MAX_VERTICES'(1) << wr_col;
  // A row not yet touched since reset takes the whole word
  assign wr_mask = row_valid_q[wr_row] ? wr_bit : '1;

  // Adjacency memory: bit-masked write, registered row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr && edge_ok) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        if (wr_mask[k]) begin
          adj_mem[wr_row][k] <= wr_bit[k];
        end
      end
    end
    if (cmd_i.row_rd) begin
      row_raw_q <= adj_mem[i_q];
    end
  end

  assign row_eff = row_ok_q ? row_raw_q : '0;

  // Color memory: write current vertex, read scanned neighbour
  always_ff @(posedge clk_i) begin
    if (cmd_i.color_wr) begin
      vcol_mem[i_q] <= c_q;
    end
    if (cmd_i.scan && scan_more) begin
      col_rd_q <= vcol_mem[j_q];
    end
  end

  assign scan_more = (j_q != i_q);

  // Control registers: row valid bits, config, counters, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      row_ok_q    <= 1'b0;
      vcount_q    <= VERTEX_COUNT_RESET;
      edges_q     <= '0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      if (cmd_i.edge_wr && edge_ok) begin
        row_valid_q[wr_row] <= 1'b1;
        if (edges_q != EDGES_SAT) begin
          edges_q <= edges_q + EDGES_W'(1);
        end
      end
      if (cmd_i.row_rd) begin
        row_ok_q <= row_valid_q[i_q];
      end
      hit_q <= cmd_i.scan && scan_more && row_eff[j_q];
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign used_cand = NW'(c_q) + NW'(1);

  // Walk counters and taken-color set
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      i_q    <= '0;
      used_q <= '0;
      n_q    <= n_eff;
    end
    if (cmd_i.next_vtx) begin
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.row_rd) begin
      j_q     <= '0;
      c_q     <= '0;
      taken_q <= '0;
    end else begin
      if (cmd_i.scan && scan_more) begin
        j_q <= j_q + AW'(1);
      end
      if (hit_q) begin
        taken_q[col_rd_q] <= 1'b1;
      end
      if (cmd_i.srch && taken_q[c_q]) begin
        c_q <= c_q + AW'(1);
      end
    end
    if (cmd_i.color_wr && (used_cand > used_q)) begin
      used_q <= used_cand;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.colors_needed <= (int'(used_q) > int'(COLORS_SAT)) ? COLORS_SAT
                                                               : COUNT_W'(used_q);
      res_q.edges_added   <= edges_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

  assign sts_o.scan_more  = scan_more;
  assign sts_o.free_found = !taken_q[c_q];
  assign sts_o.last_vtx   = ((NW'(i_q) + NW'(1)) == n_q);
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

  // A committed color must be free and chosen after the full neighbour scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.color_wr |-> (!taken_q[c_q] && (j_q == i_q) && !hit_q))
    else $error("color committed before scan drained or onto a taken color");

  // The adjacency port never serves an edge write and a row fetch together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.edge_wr && cmd_i.row_rd))
    else $error("adjacency port conflict");

  // The result register is never reloaded while its beat is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && res_valid_q) |-> res_ready_i)
    else $error("pending result overwritten");

  // A first-fit color never exceeds the current vertex index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.color_wr |-> (c_q <= i_q))
    else $error("color above vertex index");

endmodule

@@ rtl/greedy_graph_coloring_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Beat when
// in_i     in   kind, vertex_a, vertex_b                  valid && ready
// res_o    out  colors_needed, edges_added                valid && ready
// cfg_i    in   vertex_count (7 bits)                     valid && ready (ready tied high)
//
// Add-edge items may follow back to back while no color run is in progress.
// A color item walks the vertices in order: it fetches each adjacency row, scans the
// lower neighbours' colors through the single color-memory read port, then searches first-fit.
// Reset clears the adjacency matrix at once through per-row valid bits: no clearing pass.
// Add-edge items are taken while a result beat waits; a finished run holds until res_o
// frees up.

module greedy_graph_coloring_core
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ggc_stream_if.sink          in_i,
  ggc_stream_if.source        res_o,
  ggc_stream_if.sink          cfg_i
);

  ggc_cmd_t cmd;
  ggc_sts_t sts;
  logic     in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  ggc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.data.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ggc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .vertex_a_i  (in_i.data.vertex_a),
    .vertex_b_i  (in_i.data.vertex_b),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_data_o  (res_o.data)
  );

endmodule
